/* rtl/c_subset_token_scanner_unit_defines.svh */
// Assertion macros used by the token scanner RTL.
`ifndef C_SUBSET_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define C_SUBSET_TOKEN_SCANNER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CTSU_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("ctsu assertion failed");

// Check that a condition implies another in the following cycle.
`define CTSU_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("ctsu assertion failed");

`endif

/* rtl/ctsu_pkg.sv */
// Shared widths, codes and record types of the token scanner.
`timescale 1ns / 1ps
`default_nettype none
package ctsu_pkg;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 5;
  localparam int LINE_W     = 16;
  localparam int COL_W      = 16;
  localparam int OFF_W      = 24;
  localparam int LEN_W      = 16;
  localparam int RUNQ_DEPTH = 4;
  localparam int RUNQ_AW    = $clog2(RUNQ_DEPTH);
  localparam int RUNQ_CW    = RUNQ_AW + 1;

  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CH_NL  = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_US  = 8'h5f;

  typedef enum logic [KIND_W-1:0] {
    TK_EOF     = 5'd0,
    TK_ERROR   = 5'd1,
    TK_IDENT   = 5'd2,
    TK_INT     = 5'd3,
    TK_RETURN  = 5'd4,
    TK_LITERAL = 5'd5,
    TK_LPAREN  = 5'd6,
    TK_RPAREN  = 5'd7,
    TK_LBRACE  = 5'd8,
    TK_RBRACE  = 5'd9,
    TK_SEMI    = 5'd10,
    TK_TILDE   = 5'd11,
    TK_MINUS   = 5'd12,
    TK_PLUS    = 5'd13,
    TK_STAR    = 5'd14,
    TK_SLASH   = 5'd15,
    TK_PERCENT = 5'd16,
    TK_LT      = 5'd17,
    TK_LE      = 5'd18,
    TK_GT      = 5'd19,
    TK_GE      = 5'd20,
    TK_BANG    = 5'd21,
    TK_NE      = 5'd22,
    TK_ASSIGN  = 5'd23,
    TK_EQ      = 5'd24,
    TK_AND     = 5'd25,
    TK_OR      = 5'd26
  } kind_t;

  typedef enum logic [3:0] {
    MD_IDLE    = 4'd0,
    MD_ID      = 4'd1,
    MD_ID_INT  = 4'd2,
    MD_ID_RET  = 4'd3,
    MD_NUM     = 4'd4,
    MD_SLASH   = 4'd5,
    MD_COMMENT = 4'd6,
    MD_LT      = 4'd7,
    MD_GT      = 4'd8,
    MD_BANG    = 4'd9,
    MD_EQ      = 4'd10,
    MD_AMP     = 4'd11,
    MD_PIPE    = 4'd12
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
  } token_t;

  // Tokens caused by one byte: one or two.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } run_t;

  // Letters of the keyword int, by match position.
  function automatic logic [BYTE_W-1:0] kw_int_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h69;
      3'd1:    ch = 8'h6e;
      3'd2:    ch = 8'h74;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Letters of the keyword return, by match position.
  function automatic logic [BYTE_W-1:0] kw_ret_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h75;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h6e;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

/* rtl/ctsu_front.sv */
// Scanner front: takes source bytes, tracks position and builds token runs.
`timescale 1ns / 1ps
`default_nettype none
module ctsu_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ctsu_pkg::BYTE_W-1:0] data_byte,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     q_ready,
  output logic                     push,
  output ctsu_pkg::run_t           run
);
  import ctsu_pkg::*;

  mode_t              mode, mode_next;
  logic [2:0]         kp, kp_next;
  logic [LINE_W-1:0]  line_cnt, line_cnt_next;
  logic [COL_W-1:0]   col_cnt, col_cnt_next;
  logic [OFF_W-1:0]   off_cnt, off_cnt_next;
  logic [LINE_W-1:0]  pend_line, pend_line_next;
  logic [COL_W-1:0]   pend_col, pend_col_next;
  logic [OFF_W-1:0]   pend_off, pend_off_next;
  logic [LEN_W-1:0]   pend_len, pend_len_next;

  logic              take;
  logic              is_nul, is_nl, is_num, is_letter, is_ident, is_blank;
  logic              has_pend, emit_pend, extend, to_comment, op_done, do_idle;
  logic [BYTE_W-1:0] want;
  kind_t             pend_kind, op_kind, idle_kind;
  logic              idle_emit, idle_begin;
  mode_t             idle_mode;
  logic [2:0]        idle_kp;
  logic [LEN_W-1:0]  len_inc;
  token_t            tok_a, tok_b;
  logic              b_en;

  assign in_ready = q_ready;
  assign take     = in_valid & q_ready;
  assign len_inc  = (pend_len == '1) ? pend_len : pend_len + LEN_W'(1);

  // Classify the byte and decide what this byte does to the pending token.
  always_comb begin
    is_nul    = (data_byte == CH_NUL);
    is_nl     = (data_byte == CH_NL);
    is_num    = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    is_letter = ((data_byte >= 8'h61) && (data_byte <= 8'h7a)) ||
                ((data_byte >= 8'h41) && (data_byte <= 8'h5a));
    is_ident  = is_letter || is_num || (data_byte == CH_US);
    is_blank  = (data_byte == 8'h20) || (data_byte == 8'h09) || (data_byte == 8'h0a) ||
                (data_byte == 8'h0b) || (data_byte == 8'h0c) || (data_byte == 8'h0d);

    case (mode)
      MD_ID_INT: pend_kind = (kp == 3'd3) ? TK_INT : TK_IDENT;
      MD_ID_RET: pend_kind = (kp == 3'd6) ? TK_RETURN : TK_IDENT;
      MD_ID:     pend_kind = TK_IDENT;
      MD_NUM:    pend_kind = TK_LITERAL;
      MD_SLASH:  pend_kind = TK_SLASH;
      MD_LT:     pend_kind = TK_LT;
      MD_GT:     pend_kind = TK_GT;
      MD_BANG:   pend_kind = TK_BANG;
      MD_EQ:     pend_kind = TK_ASSIGN;
      default:   pend_kind = TK_ERROR;
    endcase

    case (mode)
      MD_LT:   op_kind = TK_LE;
      MD_GT:   op_kind = TK_GE;
      MD_BANG: op_kind = TK_NE;
      MD_EQ:   op_kind = TK_EQ;
      MD_AMP:  op_kind = TK_AND;
      MD_PIPE: op_kind = TK_OR;
      default: op_kind = TK_ERROR;
    endcase

    case (mode)
      MD_AMP:  want = 8'h26;
      MD_PIPE: want = 8'h7c;
      default: want = 8'h3d;
    endcase

    case (mode)
      MD_ID, MD_ID_INT, MD_ID_RET, MD_NUM, MD_SLASH,
      MD_LT, MD_GT, MD_BANG, MD_EQ, MD_AMP, MD_PIPE: has_pend = 1'b1;
      default:                                      has_pend = 1'b0;
    endcase

    emit_pend  = 1'b0;
    extend     = 1'b0;
    to_comment = 1'b0;
    op_done    = 1'b0;
    do_idle    = 1'b0;
    if (is_nul) begin
      emit_pend = has_pend;
    end else begin
      case (mode)
        MD_ID, MD_ID_INT, MD_ID_RET, MD_NUM: begin
          if ((mode == MD_NUM) ? is_num : is_ident) begin
            extend = 1'b1;
          end else begin
            emit_pend = 1'b1;
            do_idle   = 1'b1;
          end
        end
        MD_SLASH: begin
          if (data_byte == 8'h2f) begin
            to_comment = 1'b1;
          end else begin
            emit_pend = 1'b1;
            do_idle   = 1'b1;
          end
        end
        MD_COMMENT: begin
          do_idle = is_nl;
        end
        MD_LT, MD_GT, MD_BANG, MD_EQ, MD_AMP, MD_PIPE: begin
          emit_pend = 1'b1;
          if (data_byte == want) begin
            op_done = 1'b1;
          end else begin
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    // Decode the byte as the first byte of a new token.
    idle_emit  = 1'b0;
    idle_begin = 1'b0;
    idle_kind  = TK_ERROR;
    idle_mode  = MD_IDLE;
    idle_kp    = 3'd0;
    case (data_byte)
      8'h28: begin idle_emit = 1'b1; idle_kind = TK_LPAREN;  end
      8'h29: begin idle_emit = 1'b1; idle_kind = TK_RPAREN;  end
      8'h7b: begin idle_emit = 1'b1; idle_kind = TK_LBRACE;  end
      8'h7d: begin idle_emit = 1'b1; idle_kind = TK_RBRACE;  end
      8'h3b: begin idle_emit = 1'b1; idle_kind = TK_SEMI;    end
      8'h7e: begin idle_emit = 1'b1; idle_kind = TK_TILDE;   end
      8'h2d: begin idle_emit = 1'b1; idle_kind = TK_MINUS;   end
      8'h2b: begin idle_emit = 1'b1; idle_kind = TK_PLUS;    end
      8'h2a: begin idle_emit = 1'b1; idle_kind = TK_STAR;    end
      8'h25: begin idle_emit = 1'b1; idle_kind = TK_PERCENT; end
      8'h2f: begin idle_begin = 1'b1; idle_mode = MD_SLASH; end
      8'h3c: begin idle_begin = 1'b1; idle_mode = MD_LT;    end
      8'h3e: begin idle_begin = 1'b1; idle_mode = MD_GT;    end
      8'h21: begin idle_begin = 1'b1; idle_mode = MD_BANG;  end
      8'h3d: begin idle_begin = 1'b1; idle_mode = MD_EQ;    end
      8'h26: begin idle_begin = 1'b1; idle_mode = MD_AMP;   end
      8'h7c: begin idle_begin = 1'b1; idle_mode = MD_PIPE;  end
      default: begin
        if (is_letter || (data_byte == CH_US)) begin
          idle_begin = 1'b1;
          if (data_byte == 8'h69) begin
            idle_mode = MD_ID_INT;
            idle_kp   = 3'd1;
          end else if (data_byte == 8'h72) begin
            idle_mode = MD_ID_RET;
            idle_kp   = 3'd1;
          end else begin
            idle_mode = MD_ID;
          end
        end else if (is_num) begin
          idle_begin = 1'b1;
          idle_mode  = MD_NUM;
        end else if (!is_blank) begin
          idle_emit = 1'b1;
        end
      end
    endcase
  end

  // Next state: position counters, scan mode, keyword match and pending token.
  always_comb begin
    mode_next      = mode;
    kp_next        = kp;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    off_cnt_next   = off_cnt;
    pend_line_next = pend_line;
    pend_col_next  = pend_col;
    pend_off_next  = pend_off;
    pend_len_next  = pend_len;
    if (take) begin
      if (is_nul) begin
        mode_next      = MD_IDLE;
        kp_next        = 3'd0;
        line_cnt_next  = LINE_W'(1);
        col_cnt_next   = COL_W'(1);
        off_cnt_next   = '0;
        pend_line_next = '0;
        pend_col_next  = '0;
        pend_off_next  = '0;
        pend_len_next  = '0;
      end else begin
        // Advance the source position by one byte.
        if (is_nl) begin
          line_cnt_next = (line_cnt == '1) ? line_cnt : line_cnt + LINE_W'(1);
          col_cnt_next  = COL_W'(1);
        end else begin
          col_cnt_next = (col_cnt == '1) ? col_cnt : col_cnt + COL_W'(1);
        end
        off_cnt_next = (off_cnt == '1) ? off_cnt : off_cnt + OFF_W'(1);

        if (extend) begin
          pend_len_next = len_inc;
          if (mode == MD_ID_INT) begin
            if ((kp < 3'd3) && (data_byte == kw_int_char(kp))) begin
              kp_next = kp + 3'd1;
            end else begin
              mode_next = MD_ID;
              kp_next   = 3'd0;
            end
          end else if (mode == MD_ID_RET) begin
            if ((kp < 3'd6) && (data_byte == kw_ret_char(kp))) begin
              kp_next = kp + 3'd1;
            end else begin
              mode_next = MD_ID;
              kp_next   = 3'd0;
            end
          end
        end
        if (to_comment) begin
          mode_next = MD_COMMENT;
        end
        if (op_done) begin
          mode_next = MD_IDLE;
          kp_next   = 3'd0;
        end
        if (do_idle) begin
          mode_next = MD_IDLE;
          kp_next   = 3'd0;
          if (idle_begin) begin
            mode_next      = idle_mode;
            kp_next        = idle_kp;
            pend_line_next = line_cnt;
            pend_col_next  = col_cnt;
            pend_off_next  = off_cnt;
            pend_len_next  = LEN_W'(1);
          end
        end
      end
    end
  end

  // Outputs: assemble the run of tokens that this byte causes.
  always_comb begin
    tok_a.kind = op_done ? op_kind : pend_kind;
    tok_a.line = pend_line;
    tok_a.col  = pend_col;
    tok_a.off  = pend_off;
    tok_a.len  = op_done ? len_inc : pend_len;

    tok_b.kind = is_nul ? TK_EOF : idle_kind;
    tok_b.line = line_cnt;
    tok_b.col  = col_cnt;
    tok_b.off  = off_cnt;
    tok_b.len  = is_nul ? '0 : LEN_W'(1);
    b_en       = is_nul || (do_idle && idle_emit);

    if (emit_pend) begin
      run.tok0 = tok_a;
      run.tok1 = tok_b;
      run.two  = b_en;
    end else begin
      run.tok0 = tok_b;
      run.tok1 = tok_b;
      run.two  = 1'b0;
    end
    push = take && (emit_pend || b_en);
  end

  // Hold scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MD_IDLE;
      kp        <= 3'd0;
      line_cnt  <= LINE_W'(1);
      col_cnt   <= COL_W'(1);
      off_cnt   <= '0;
      pend_line <= '0;
      pend_col  <= '0;
      pend_off  <= '0;
      pend_len  <= '0;
    end else begin
      mode      <= mode_next;
      kp        <= kp_next;
      line_cnt  <= line_cnt_next;
      col_cnt   <= col_cnt_next;
      off_cnt   <= off_cnt_next;
      pend_line <= pend_line_next;
      pend_col  <= pend_col_next;
      pend_off  <= pend_off_next;
      pend_len  <= pend_len_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/ctsu_back.sv */
// Scanner back: queue of token runs and the output register that serializes them.
`timescale 1ns / 1ps
`default_nettype none
`include "c_subset_token_scanner_unit_defines.svh"
module ctsu_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  ctsu_pkg::run_t              run,
  output logic                        q_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ctsu_pkg::token_t            tok,
  output logic                        last
);
  import ctsu_pkg::*;

  run_t               q_mem [RUNQ_DEPTH];
  logic [RUNQ_AW-1:0] wr_ptr, rd_ptr;
  logic [RUNQ_CW-1:0] cnt;
  logic               q_empty, pop, out_take;
  run_t               cur;
  logic               cur_valid, idx;

  assign q_empty   = (cnt == '0);
  assign q_ready   = (cnt != RUNQ_CW'(RUNQ_DEPTH));
  assign out_valid = cur_valid;
  assign tok       = idx ? cur.tok1 : cur.tok0;
  assign last      = idx || !cur.two;
  assign out_take  = cur_valid && out_ready;
  assign pop       = !q_empty && (!cur_valid || (out_take && last));

  // Write runs into the queue.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= run;
    end
  end

  // Advance queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + RUNQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RUNQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + RUNQ_CW'(1);
        2'b01:   cnt <= cnt - RUNQ_CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  // Load the next run into the output register, or step to its second token.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 1'b0;
    end else if (out_take && last) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (out_take) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_mem[rd_ptr];
    end
  end

  `CTSU_ASSERT_IMPLIES(a_cnt_range, clk, rst, 1'b1, cnt <= RUNQ_CW'(RUNQ_DEPTH))
  `CTSU_ASSERT_IMPLIES(a_push_room, clk, rst, push, cnt != RUNQ_CW'(RUNQ_DEPTH))
  `CTSU_ASSERT_IMPLIES(a_second_only_pairs, clk, rst, cur_valid && idx, cur.two)
  `CTSU_ASSERT_NEXT(a_drain_empty, clk, rst, out_take && last && q_empty, !cur_valid)

endmodule
`default_nettype wire

/* rtl/c_subset_token_scanner_unit.sv */
// Top level of the C subset token scanner.
//
// Input channel: one source byte per transaction on data_byte with
// in_valid/in_ready. A zero byte ends the source: any pending token is
// flushed, an eof token follows, and position counting restarts.
// Output channel: one token per transaction with out_valid/out_ready;
// last_of_run marks the final token caused by a given byte.
// The first token caused by a byte passes through the run queue and then
// the output register. Tokens that wait for a following byte (identifiers,
// literals, operators that may take a second character) appear once that
// byte arrives.
// Throughput: one byte per cycle while the run queue has room. A byte
// that causes two tokens holds the output register for both of them; a
// four-entry run queue between the scanner front and the output register
// absorbs such bursts. Receiver stall: tokens stay in the queue; in_ready
// drops only when the queue is full. Reset: position is line 1, column 1,
// offset 0, no token pending, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none
module c_subset_token_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [23:0] start_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);
  import ctsu_pkg::*;

  logic   q_ready, push;
  run_t   run;
  token_t tok;

  ctsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_ready   (q_ready),
    .push      (push),
    .run       (run)
  );

  ctsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .run       (run),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tok       (tok),
    .last      (last_of_run)
  );

  // Drive token fields.
  assign token_kind   = tok.kind;
  assign start_line   = tok.line;
  assign start_column = tok.col;
  assign start_offset = tok.off;
  assign token_length = tok.len;

endmodule
`default_nettype wire

/* tb/c_subset_token_scanner_checker.sv */
// Token checker for the C subset scanner: predicts each token and compares it.
`timescale 1ns / 1ps
module c_subset_token_scanner_checker
  import ctsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] token_kind,
  input  logic [LINE_W-1:0] start_line,
  input  logic [COL_W-1:0]  start_column,
  input  logic [OFF_W-1:0]  start_offset,
  input  logic [LEN_W-1:0]  token_length,
  input  logic              last_of_run,
  output int                fail_count,
  output int                due_count
);

  typedef struct packed {
    token_t tok;
    logic   last;
  } due_tok_t;

  localparam logic [23:0] WORD_INT = "int";
  localparam logic [47:0] WORD_RET = "return";

  // Scanner state as the predictor sees it
  mode_t             mode;
  logic [2:0]        kw_pos;
  logic [LINE_W-1:0] line_no;
  logic [COL_W-1:0]  col_no;
  logic [OFF_W-1:0]  byte_pos;
  logic [LINE_W-1:0] held_line;
  logic [COL_W-1:0]  held_col;
  logic [OFF_W-1:0]  held_off;
  logic [LEN_W-1:0]  held_len;

  due_tok_t tokens_due[$];
  due_tok_t run_buf[2];
  int       run_len;

  function automatic logic [LINE_W-1:0] bump_line(input logic [LINE_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [COL_W-1:0] bump_col(input logic [COL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFF_W-1:0] bump_off(input logic [OFF_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] bump_len(input logic [LEN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return is_letter(c) || is_numeral(c) || c == CH_US;
  endfunction

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == CH_NL || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic bit holding();
    return mode >= MD_ID && mode <= MD_PIPE && mode != MD_COMMENT;
  endfunction

  function automatic kind_t held_kind();
    case (mode)
      MD_ID_INT: return (kw_pos == 3'd3) ? TK_INT : TK_IDENT;
      MD_ID_RET: return (kw_pos == 3'd6) ? TK_RETURN : TK_IDENT;
      MD_ID:     return TK_IDENT;
      MD_NUM:    return TK_LITERAL;
      MD_SLASH:  return TK_SLASH;
      MD_LT:     return TK_LT;
      MD_GT:     return TK_GT;
      MD_BANG:   return TK_BANG;
      MD_EQ:     return TK_ASSIGN;
      default:   return TK_ERROR;
    endcase
  endfunction

  task automatic clear_scan();
    mode      = MD_IDLE;
    kw_pos    = '0;
    line_no   = LINE_W'(1);
    col_no    = COL_W'(1);
    byte_pos  = '0;
    held_line = '0;
    held_col  = '0;
    held_off  = '0;
    held_len  = '0;
  endtask

  // Advance position past one nonzero byte
  task automatic step_pos(input logic [7:0] c);
    if (c == CH_NL) begin
      line_no = bump_line(line_no);
      col_no  = COL_W'(1);
    end else begin
      col_no = bump_col(col_no);
    end
    byte_pos = bump_off(byte_pos);
  endtask

  task automatic add_tok(input kind_t k, input logic [LINE_W-1:0] ln,
                         input logic [COL_W-1:0] cl, input logic [OFF_W-1:0] of,
                         input logic [LEN_W-1:0] len);
    run_buf[run_len].tok.kind = k;
    run_buf[run_len].tok.line = ln;
    run_buf[run_len].tok.col  = cl;
    run_buf[run_len].tok.off  = of;
    run_buf[run_len].tok.len  = len;
    run_buf[run_len].last     = 1'b0;
    run_len++;
  endtask

  task automatic take_held(input kind_t k);
    add_tok(k, held_line, held_col, held_off, held_len);
    mode   = MD_IDLE;
    kw_pos = '0;
  endtask

  task automatic open_held(input mode_t m, input logic [7:0] c);
    mode      = m;
    held_line = line_no;
    held_col  = col_no;
    held_off  = byte_pos;
    held_len  = LEN_W'(1);
    step_pos(c);
  endtask

  task automatic one_char(input kind_t k, input logic [7:0] c);
    add_tok(k, line_no, col_no, byte_pos, LEN_W'(1));
    step_pos(c);
  endtask

  // Byte seen with nothing pending
  task automatic scan_fresh(input logic [7:0] c);
    mode   = MD_IDLE;
    kw_pos = '0;
    if (is_blank(c)) begin
      step_pos(c);
    end else begin
      case (c)
        "(": one_char(TK_LPAREN, c);
        ")": one_char(TK_RPAREN, c);
        "{": one_char(TK_LBRACE, c);
        "}": one_char(TK_RBRACE, c);
        ";": one_char(TK_SEMI, c);
        "~": one_char(TK_TILDE, c);
        "-": one_char(TK_MINUS, c);
        "+": one_char(TK_PLUS, c);
        "*": one_char(TK_STAR, c);
        "%": one_char(TK_PERCENT, c);
        "/": open_held(MD_SLASH, c);
        "<": open_held(MD_LT, c);
        ">": open_held(MD_GT, c);
        "!": open_held(MD_BANG, c);
        "=": open_held(MD_EQ, c);
        "&": open_held(MD_AMP, c);
        "|": open_held(MD_PIPE, c);
        default: begin
          if (is_letter(c) || c == CH_US) begin
            if (c == "i") begin
              open_held(MD_ID_INT, c);
              kw_pos = 3'd1;
            end else if (c == "r") begin
              open_held(MD_ID_RET, c);
              kw_pos = 3'd1;
            end else begin
              open_held(MD_ID, c);
            end
          end else if (is_numeral(c)) begin
            open_held(MD_NUM, c);
          end else begin
            one_char(TK_ERROR, c);
          end
        end
      endcase
    end
  endtask

  // Predict the tokens one accepted byte causes and queue them
  task automatic scan_byte(input logic [7:0] c);
    bit          done;
    logic [7:0]  want;
    kind_t       k;
    done    = 1'b0;
    run_len = 0;
    if (c == CH_NUL) begin
      // flush any pending token, then eof, then restart
      if (holding()) take_held(held_kind());
      add_tok(TK_EOF, line_no, col_no, byte_pos, '0);
      clear_scan();
    end else begin
      case (mode)
        MD_ID, MD_ID_INT, MD_ID_RET, MD_NUM: begin
          if (mode == MD_NUM ? is_numeral(c) : is_word_char(c)) begin
            if (mode == MD_ID_INT) begin
              if (kw_pos < 3'd3 && c == WORD_INT[8*(2-kw_pos) +: 8]) begin
                kw_pos++;
              end else begin
                mode   = MD_ID;
                kw_pos = '0;
              end
            end else if (mode == MD_ID_RET) begin
              if (kw_pos < 3'd6 && c == WORD_RET[8*(5-kw_pos) +: 8]) begin
                kw_pos++;
              end else begin
                mode   = MD_ID;
                kw_pos = '0;
              end
            end
            held_len = bump_len(held_len);
            step_pos(c);
            done = 1'b1;
          end else begin
            take_held(held_kind());
          end
        end
        MD_SLASH: begin
          if (c == "/") begin
            mode = MD_COMMENT;
            step_pos(c);
            done = 1'b1;
          end else begin
            take_held(held_kind());
          end
        end
        MD_COMMENT: begin
          if (c != CH_NL) begin
            step_pos(c);
            done = 1'b1;
          end
        end
        MD_LT, MD_GT, MD_BANG, MD_EQ, MD_AMP, MD_PIPE: begin
          want = (mode == MD_AMP) ? "&" : ((mode == MD_PIPE) ? "|" : "=");
          if (c == want) begin
            // second character completes a two-character operator
            if (mode == MD_AMP) k = TK_AND;
            else if (mode == MD_PIPE) k = TK_OR;
            else k = kind_t'(held_kind() + 1);
            held_len = bump_len(held_len);
            take_held(k);
            step_pos(c);
            done = 1'b1;
          end else begin
            take_held(held_kind());
          end
        end
        default: ;
      endcase
      if (!done) scan_fresh(c);
    end
    for (int i = 0; i < run_len; i++) begin
      run_buf[i].last = (i == run_len - 1);
      tokens_due.push_back(run_buf[i]);
    end
  endtask

  function automatic bit field_bad(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compare one output transaction with the oldest predicted token
  task automatic check_token();
    due_tok_t want;
    bit       bad;
    if (tokens_due.size() == 0) begin
      $display("%0t: unexpected token kind %0d line %0d column %0d", $time,
               token_kind, start_line, start_column);
      fail_count++;
    end else begin
      want = tokens_due.pop_front();
      bad  = 1'b0;
      bad |= field_bad("token_kind", 64'(want.tok.kind), 64'(token_kind));
      bad |= field_bad("start_line", 64'(want.tok.line), 64'(start_line));
      bad |= field_bad("start_column", 64'(want.tok.col), 64'(start_column));
      bad |= field_bad("start_offset", 64'(want.tok.off), 64'(start_offset));
      bad |= field_bad("token_length", 64'(want.tok.len), 64'(token_length));
      bad |= field_bad("last_of_run", 64'(want.last), 64'(last_of_run));
      if (bad) fail_count++;
    end
  endtask

  // Sample both channels; check outputs before predicting the new byte
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      tokens_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) check_token();
      if (in_valid && in_ready) scan_byte(data_byte);
    end
    due_count = tokens_due.size();
  end

endmodule

/* tb/tb_c_subset_token_scanner_unit.sv */
// Testbench top for the C subset token scanner: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_c_subset_token_scanner_unit;
  import ctsu_pkg::*;

  localparam int DEAD_LIMIT = 2000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [4:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  int fail_count;
  int due_count;
  int bytes_sent  = 0;
  int stall_left  = 0;
  int dead_cycles = 0;
  bit calm        = 1'b0;
  bit quiet       = 1'b0;

  string      word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string      singles    = "(){};~-+*%";
  string      starters   = "<>!=/&|";
  string      near_words[8] = '{"in", "i", "retur", "re", "intx", "return_", "r9", "int0"};
  string      pairs[6]      = '{"<=", ">=", "!=", "==", "&&", "||"};
  logic [7:0] blanks[6]     = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  c_subset_token_scanner_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .start_line   (start_line),
    .start_column (start_column),
    .start_offset (start_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  c_subset_token_scanner_checker token_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .start_line   (start_line),
    .start_column (start_column),
    .start_offset (start_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .due_count    (due_count)
  );

  // Stall the receiver in random bursts; toggle quiet stretches now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) quiet = !quiet;
    if (calm) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) dead_cycles = 0;
    else dead_cycles++;
    if (dead_cycles >= DEAD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte, with an optional gap, and hold it until accepted.
  // Called and returns at a falling edge; valid stays high for the caller.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && !quiet && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Mostly well-formed lexemes, glued or blank-separated, with some noise
  task automatic send_fragment();
    int pick;
    pick = $urandom_range(0, 17);
    case (pick)
      0: send_text("int");
      1: send_text("return");
      2: send_text(near_words[$urandom_range(0, 7)]);
      3, 4: begin
        send_byte(word_chars[$urandom_range(0, 52)]);
        repeat ($urandom_range(0, 7)) send_byte(word_chars[$urandom_range(0, 62)]);
      end
      5: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(48, 57)));
      6: send_byte(singles[$urandom_range(0, 9)]);
      7: send_text(pairs[$urandom_range(0, 5)]);
      8: send_byte(starters[$urandom_range(0, 6)]);
      9: begin
        send_text("//");
        repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) == 0) send_byte(CH_NUL);
        else send_byte(CH_NL);
      end
      10: send_byte(8'($urandom_range(1, 255)));
      11: send_byte(8'($urandom_range(128, 255)));
      12: if ($urandom_range(0, 1) == 1) send_byte(CH_NUL);
      default: send_byte(blanks[$urandom_range(0, 5)]);
    endcase
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Keywords, slash then comment, two-char operators, lone bar and
    // ampersand, literal closed by a high byte, unknown byte, flush at end
    send_text("int return/x//\n<=!=&&|&9");
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(CH_NUL);

    // Hold the sender until every token has drained
    in_valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    while (bytes_sent < 1000) send_fragment();
    calm = 1'b1;
    while (bytes_sent < 1150) send_fragment();
    send_byte(CH_NUL);

    in_valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
